FILE: hdl/multichannel_pcm_frame_fifo_macros.svh
// assertion macros for the pcm frame fifo checks
`ifndef MULTICHANNEL_PCM_FRAME_FIFO_MACROS_SVH
`define MULTICHANNEL_PCM_FRAME_FIFO_MACROS_SVH

// same-cycle implication
`define MPFF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mpff check failed");

// next-cycle implication
`define MPFF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mpff check failed");

`endif

FILE: hdl/mpff_pkg.sv
// shared constants and types of the pcm frame fifo
`timescale 1ns / 1ps
package mpff_pkg;

  localparam int DEPTH_FRAMES = 1024;
  localparam int MAX_CHANNELS = 8;
  localparam int ADDR_W       = $clog2(DEPTH_FRAMES);
  localparam int CNT_W        = 11;
  localparam int SAMPLE_W     = 16;
  localparam int CHAN_W       = 4;
  localparam int PADDR_W      = 3;
  localparam int PDATA_W      = 32;

  localparam logic [CNT_W-1:0]  DEPTH_CNT  = CNT_W'(DEPTH_FRAMES);
  localparam logic [CNT_W-1:0]  TALLY_MAX  = '1;
  localparam logic [CNT_W-1:0]  CAP_RESET  = CNT_W'(1024);
  localparam logic [CHAN_W-1:0] CHAN_RESET = CHAN_W'(2);
  localparam logic [CHAN_W-1:0] CHAN_MAX   = CHAN_W'(MAX_CHANNELS);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_CHANNELS = 1'b1;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic              ok;
    logic              rd;
    logic [CNT_W-1:0]  held;
    logic [CNT_W-1:0]  tally;
  } mpff_cmd_t;

endpackage

FILE: hdl/mpff_ram.sv
// generic single-port ram with registered read
`timescale 1ns / 1ps
module mpff_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/mpff_lane.sv
// one sample lane: storage for one channel and read gating
`timescale 1ns / 1ps
module mpff_lane (
  input  logic                          clk_i,
  input  logic                          lane_en_i,
  input  logic                          we_i,
  input  logic                          re_i,
  input  logic [mpff_pkg::ADDR_W-1:0]   addr_i,
  input  logic [mpff_pkg::SAMPLE_W-1:0] wdata_i,
  input  logic                          show_i,
  output logic [mpff_pkg::SAMPLE_W-1:0] sample_o
);
  import mpff_pkg::*;

  logic [SAMPLE_W-1:0] rdata;

  mpff_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(DEPTH_FRAMES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we_i & lane_en_i),
    .re_i   (re_i & lane_en_i),
    .addr_i (addr_i),
    .wdata_i(wdata_i),
    .rdata_o(rdata)
  );

  assign sample_o = (show_i && lane_en_i) ? rdata : '0;

endmodule

FILE: hdl/mpff_ctrl.sv
// pointer, fill count and call tally control
`timescale 1ns / 1ps
module mpff_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       clear_i,
  input  logic                       accept_i,
  input  logic                       opcode_i,
  input  logic                       last_frame_i,
  input  logic [mpff_pkg::CNT_W-1:0] cap_i,
  output mpff_pkg::mpff_cmd_t        cmd_o
);
  import mpff_pkg::*;

  logic [ADDR_W-1:0] rp_q, rp_d;
  logic [CNT_W-1:0]  held_q, held_d;
  logic [CNT_W-1:0]  tally_q, tally_d;
  logic              rd, ok;
  logic [CNT_W:0]    wr_sum;
  logic [CNT_W:0]    wr_slot;
  logic [CNT_W-1:0]  rd_slot;
  logic [CNT_W-1:0]  rd_next;
  logic [CNT_W-1:0]  held_new;
  logic [CNT_W-1:0]  tally_new;

  always_comb begin
    rd      = (opcode_i == OP_READ);
    wr_sum  = (CNT_W+1)'(rp_q) + (CNT_W+1)'(held_q);
    wr_slot = (wr_sum >= (CNT_W+1)'(cap_i)) ? wr_sum - (CNT_W+1)'(cap_i) : wr_sum;
    rd_slot = (CNT_W'(rp_q) >= cap_i) ? '0 : CNT_W'(rp_q);
    rd_next = ((rd_slot + CNT_W'(1)) >= cap_i) ? '0 : rd_slot + CNT_W'(1);
    ok      = rd ? (held_q != '0) : (held_q < cap_i);

    held_new = held_q;
    if (ok) begin
      held_new = rd ? held_q - CNT_W'(1) : held_q + CNT_W'(1);
    end
    tally_new = (ok && tally_q != TALLY_MAX) ? tally_q + CNT_W'(1) : tally_q;

    cmd_o.we    = accept_i && ok && !rd;
    cmd_o.re    = accept_i && ok && rd;
    cmd_o.addr  = rd ? rd_slot[ADDR_W-1:0] : wr_slot[ADDR_W-1:0];
    cmd_o.ok    = ok;
    cmd_o.rd    = rd;
    cmd_o.held  = held_new;
    cmd_o.tally = tally_new;

    rp_d    = rp_q;
    held_d  = held_q;
    tally_d = tally_q;
    if (clear_i) begin
      rp_d    = '0;
      held_d  = '0;
      tally_d = '0;
    end else if (accept_i) begin
      if (ok && rd) begin
        rp_d = rd_next[ADDR_W-1:0];
      end
      held_d  = held_new;
      tally_d = last_frame_i ? '0 : tally_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q    <= '0;
      held_q  <= '0;
      tally_q <= '0;
    end else begin
      rp_q    <= rp_d;
      held_q  <= held_d;
      tally_q <= tally_d;
    end
  end

endmodule

FILE: hdl/multichannel_pcm_frame_fifo.sv
// top level of the multichannel pcm frame fifo
//
//   port group   handshake               carries
//   config       psel/penable/pready     frame_capacity, channel_count
//   in           in_valid_i/in_ready_o   opcode, last_frame, 8 samples
//   out          out_valid_o/out_ready_i accepted, frames_held, call_tally, 8 samples
//
// in the accept cycle of an item the pointers update and the lane ram access starts,
// and once out is free the response state moves the registered ram data into the output register
// one item at a time, so the input takes no new item until the last one is in the output register
// a stalled output keeps the finished item in the pending stage until it is taken
// reset empties the buffer; ram contents are not cleared
`timescale 1ns / 1ps
module multichannel_pcm_frame_fifo (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mpff_pkg::PADDR_W-1:0]      paddr,
  input  logic [mpff_pkg::PDATA_W-1:0]      pwdata,
  output logic [mpff_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              opcode_i,
  input  logic                              last_frame_i,
  input  logic signed [mpff_pkg::SAMPLE_W-1:0] sample_in_0_i,
  input  logic signed [mpff_pkg::SAMPLE_W-1:0] sample_in_1_i,
  input  logic signed [mpff_pkg::SAMPLE_W-1:0] sample_in_2_i,
  input  logic signed [mpff_pkg::SAMPLE_W-1:0] sample_in_3_i,
  input  logic signed [mpff_pkg::SAMPLE_W-1:0] sample_in_4_i,
  input  logic signed [mpff_pkg::SAMPLE_W-1:0] sample_in_5_i,
  input  logic signed [mpff_pkg::SAMPLE_W-1:0] sample_in_6_i,
  input  logic signed [mpff_pkg::SAMPLE_W-1:0] sample_in_7_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              accepted_o,
  output logic [mpff_pkg::CNT_W-1:0]        frames_held_o,
  output logic [mpff_pkg::CNT_W-1:0]        call_tally_o,
  output logic signed [mpff_pkg::SAMPLE_W-1:0] sample_out_0_o,
  output logic signed [mpff_pkg::SAMPLE_W-1:0] sample_out_1_o,
  output logic signed [mpff_pkg::SAMPLE_W-1:0] sample_out_2_o,
  output logic signed [mpff_pkg::SAMPLE_W-1:0] sample_out_3_o,
  output logic signed [mpff_pkg::SAMPLE_W-1:0] sample_out_4_o,
  output logic signed [mpff_pkg::SAMPLE_W-1:0] sample_out_5_o,
  output logic signed [mpff_pkg::SAMPLE_W-1:0] sample_out_6_o,
  output logic signed [mpff_pkg::SAMPLE_W-1:0] sample_out_7_o
);
  import mpff_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RESP = 1'b1;

  logic              state_q, state_d;
  logic [CNT_W-1:0]  cap_q;
  logic [CHAN_W-1:0] chan_q;
  logic [CNT_W-1:0]  cap_eff;
  logic [CHAN_W-1:0] chan_eff;
  logic              cfg_wr;
  logic              accept;
  logic              load;
  mpff_cmd_t         cmd;
  mpff_cmd_t         pend_q;

  logic [SAMPLE_W-1:0] wdata    [MAX_CHANNELS];
  logic [SAMPLE_W-1:0] lane_out [MAX_CHANNELS];
  logic [SAMPLE_W-1:0] smp_q    [MAX_CHANNELS];
  logic                out_valid_q;
  logic                acc_q;
  logic [CNT_W-1:0]    held_q;
  logic [CNT_W-1:0]    tally_q;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= CAP_RESET;
      chan_q <= CHAN_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_CAPACITY: cap_q  <= pwdata[CNT_W-1:0];
        REG_CHANNELS: chan_q <= pwdata[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_CAPACITY: prdata = PDATA_W'(cap_q);
      REG_CHANNELS: prdata = PDATA_W'(chan_q);
      default:      prdata = '0;
    endcase
  end

  always_comb begin
    cap_eff = cap_q;
    if (cap_q == '0) begin
      cap_eff = CNT_W'(1);
    end else if (cap_q > DEPTH_CNT) begin
      cap_eff = DEPTH_CNT;
    end
    chan_eff = chan_q;
    if (chan_q == '0) begin
      chan_eff = CHAN_W'(1);
    end else if (chan_q > CHAN_MAX) begin
      chan_eff = CHAN_MAX;
    end
  end

  // input side
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign load       = (state_q == ST_RESP) && (!out_valid_q || out_ready_i);

  assign wdata[0] = sample_in_0_i;
  assign wdata[1] = sample_in_1_i;
  assign wdata[2] = sample_in_2_i;
  assign wdata[3] = sample_in_3_i;
  assign wdata[4] = sample_in_4_i;
  assign wdata[5] = sample_in_5_i;
  assign wdata[6] = sample_in_6_i;
  assign wdata[7] = sample_in_7_i;

  mpff_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (cfg_wr),
    .accept_i    (accept),
    .opcode_i    (opcode_i),
    .last_frame_i(last_frame_i),
    .cap_i       (cap_eff),
    .cmd_o       (cmd)
  );

  for (genvar g = 0; g < MAX_CHANNELS; g++) begin : g_lane
    mpff_lane u_lane (
      .clk_i    (clk_i),
      .lane_en_i(CHAN_W'(g) < chan_eff),
      .we_i     (cmd.we),
      .re_i     (cmd.re),
      .addr_i   (cmd.addr),
      .wdata_i  (wdata[g]),
      .show_i   (pend_q.ok & pend_q.rd),
      .sample_o (lane_out[g])
    );
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_RESP;
      ST_RESP: if (load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // merge stage
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_q <= cmd;
    end
    if (load) begin
      acc_q   <= pend_q.ok;
      held_q  <= pend_q.held;
      tally_q <= pend_q.tally;
      smp_q   <= lane_out;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign accepted_o     = acc_q;
  assign frames_held_o  = held_q;
  assign call_tally_o   = tally_q;
  assign sample_out_0_o = smp_q[0];
  assign sample_out_1_o = smp_q[1];
  assign sample_out_2_o = smp_q[2];
  assign sample_out_3_o = smp_q[3];
  assign sample_out_4_o = smp_q[4];
  assign sample_out_5_o = smp_q[5];
  assign sample_out_6_o = smp_q[6];
  assign sample_out_7_o = smp_q[7];

endmodule

FILE: hdl/mpff_checker.sv
// port-level checks of the pcm frame fifo and their binding
`timescale 1ns / 1ps
`include "multichannel_pcm_frame_fifo_macros.svh"
module mpff_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic                              accepted_o,
  input logic [mpff_pkg::SAMPLE_W-1:0]     sample_out_0_o,
  input logic [mpff_pkg::SAMPLE_W-1:0]     sample_out_1_o,
  input logic [mpff_pkg::SAMPLE_W-1:0]     sample_out_2_o,
  input logic [mpff_pkg::SAMPLE_W-1:0]     sample_out_3_o,
  input logic [mpff_pkg::SAMPLE_W-1:0]     sample_out_4_o,
  input logic [mpff_pkg::SAMPLE_W-1:0]     sample_out_5_o,
  input logic [mpff_pkg::SAMPLE_W-1:0]     sample_out_6_o,
  input logic [mpff_pkg::SAMPLE_W-1:0]     sample_out_7_o
);
  import mpff_pkg::*;

  logic [SAMPLE_W-1:0] lo_or;
  logic [SAMPLE_W-1:0] hi_or;

  assign lo_or = sample_out_0_o | sample_out_1_o | sample_out_2_o | sample_out_3_o;
  assign hi_or = sample_out_4_o | sample_out_5_o | sample_out_6_o | sample_out_7_o;

  `MPFF_ASSERT_NOW(a_refused_lo_zero, out_valid_o && !accepted_o, lo_or == '0)
  `MPFF_ASSERT_NOW(a_refused_hi_zero, out_valid_o && !accepted_o, hi_or == '0)
  `MPFF_ASSERT_NEXT(a_one_in_flight, in_valid_i && in_ready_o, !in_ready_o)
  `MPFF_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)

endmodule

bind multichannel_pcm_frame_fifo mpff_checker u_mpff_checker (.*);
